### src/pec_pkg.sv
`default_nettype none

package pec_pkg;

   localparam int MAX_SEGMENTS_DEFAULT = 64;
   localparam int COORD_BITS_DEFAULT   = 32;
   localparam int IN_COORD_W           = 32;
   localparam int SEG_INDEX_W          = 6;

   typedef struct packed {
      logic load;
      logic chain_start;
      logic open_step;
      logic open_capture;
      logic scan_start;
      logic scan_run;
      logic emit;
      logic emit_ring_end;
      logic emit_error;
      logic emit_last;
      logic take;
      logic clear_set;
   } pec_cmd_type;

   typedef struct packed {
      logic open_done;
      logic open_used;
      logic closed;
      logic scan_busy;
      logic any_hit;
      logic out_free;
   } pec_status_type;

endpackage

`default_nettype wire

### src/polyline_endpoint_chainer.sv
`default_nettype none

// Polyline endpoint chainer.
// The req channel carries one segment per word: start and end points and a
// last_segment flag. While no set is being chained, req_ready is high and each
// accepted word is stored; words beyond the table depth are dropped.
// A word with last_segment set stores its segment and starts chaining, and
// req_ready stays low until the whole set has been emitted or a dead end ends it.
// The rsp channel carries one word per segment placed in a ring, with its
// index, direction, ring end, dead end error and last flags.
// Each segment after the first of a ring costs one pass over the loaded
// endpoint tables, which are read one entry per cycle; opening a ring first
// steps past the used indices one at a time.
// A stalled receiver holds the result register and the chaining pauses at
// the next word until it is taken.
// Reset empties the set and returns the block to loading; the tables are not
// cleared, since only entries of the current set are read.
module polyline_endpoint_chainer #(
   parameter int MAX_SEGMENTS = pec_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int COORD_BITS   = pec_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_start_x,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_start_y,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_end_x,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_end_y,
   input  wire logic                                  req_last_segment,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic [pec_pkg::SEG_INDEX_W-1:0]            rsp_segment_index,
   output logic                                       rsp_reversed,
   output logic                                       rsp_ring_end,
   output logic                                       rsp_chain_error,
   output logic                                       rsp_last
);

   import pec_pkg::*;

   pec_cmd_type    cmd;
   pec_status_type status;

   pec_controller u_controller (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_last_segment (req_last_segment),
      .req_ready        (req_ready),
      .status           (status),
      .cmd              (cmd)
   );

   pec_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .COORD_BITS   (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .cmd               (cmd),
      .status            (status),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_segment_index (rsp_segment_index),
      .rsp_reversed      (rsp_reversed),
      .rsp_ring_end      (rsp_ring_end),
      .rsp_chain_error   (rsp_chain_error),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

### src/pec_ram.sv
`default_nettype none

module pec_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [$clog2(DEPTH)-1:0]         waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [$clog2(DEPTH)-1:0]         raddr,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/pec_datapath.sv
`default_nettype none

module pec_datapath #(
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_BITS   = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_start_x,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_start_y,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_end_x,
   input  wire logic signed [pec_pkg::IN_COORD_W-1:0] req_end_y,
   input  wire pec_pkg::pec_cmd_type                  cmd,
   output pec_pkg::pec_status_type                    status,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic [pec_pkg::SEG_INDEX_W-1:0]            rsp_segment_index,
   output logic                                       rsp_reversed,
   output logic                                       rsp_ring_end,
   output logic                                       rsp_chain_error,
   output logic                                       rsp_last
);

   import pec_pkg::*;

   localparam int IDX_W = $clog2(MAX_SEGMENTS);
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam int PT_W  = 2 * COORD_BITS;

   logic [CNT_W-1:0]        count_ff;
   logic [MAX_SEGMENTS-1:0] used_ff;
   logic [CNT_W-1:0]        open_idx_ff;
   logic [CNT_W-1:0]        scan_addr_ff;
   logic                    rd_valid_ff;
   logic [IDX_W-1:0]        rd_idx_ff;
   logic                    fwd_hit_ff;
   logic                    rev_hit_ff;
   logic [IDX_W-1:0]        fwd_idx_ff;
   logic [IDX_W-1:0]        rev_idx_ff;
   logic [PT_W-1:0]         fwd_pt_ff;
   logic [PT_W-1:0]         rev_pt_ff;
   logic [PT_W-1:0]         ring_start_ff;
   logic [PT_W-1:0]         open_end_ff;
   logic [IDX_W-1:0]        pend_idx_ff;
   logic                    pend_rev_ff;
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic                    rsp_rev_ff;
   logic                    rsp_ring_end_ff;
   logic                    rsp_error_ff;
   logic                    rsp_last_ff;

   logic                    write_en;
   logic [PT_W-1:0]         start_wdata;
   logic [PT_W-1:0]         end_wdata;
   logic [IDX_W-1:0]        raddr;
   logic [PT_W-1:0]         start_q;
   logic [PT_W-1:0]         end_q;
   logic                    scan_more;
   logic                    fwd_match;
   logic                    rev_match;
   logic [IDX_W-1:0]        take_idx;

   assign write_en    = cmd.load && (count_ff < CNT_W'(MAX_SEGMENTS));
   assign start_wdata = {req_start_x[COORD_BITS-1:0], req_start_y[COORD_BITS-1:0]};
   assign end_wdata   = {req_end_x[COORD_BITS-1:0], req_end_y[COORD_BITS-1:0]};
   assign raddr       = cmd.scan_run ? scan_addr_ff[IDX_W-1:0] : open_idx_ff[IDX_W-1:0];
   assign scan_more   = scan_addr_ff < count_ff;
   assign fwd_match   = rd_valid_ff && !used_ff[rd_idx_ff] && (start_q == open_end_ff);
   assign rev_match   = rd_valid_ff && !used_ff[rd_idx_ff] && (end_q == open_end_ff);
   assign take_idx    = fwd_hit_ff ? fwd_idx_ff : rev_idx_ff;

   pec_ram #(.WIDTH(PT_W), .DEPTH(MAX_SEGMENTS)) u_start_ram (
      .clock (clock),
      .we    (write_en),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (start_wdata),
      .raddr (raddr),
      .rdata (start_q)
   );

   pec_ram #(.WIDTH(PT_W), .DEPTH(MAX_SEGMENTS)) u_end_ram (
      .clock (clock),
      .we    (write_en),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (end_wdata),
      .raddr (raddr),
      .rdata (end_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         used_ff  <= '0;
      end else if (cmd.clear_set) begin
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         if (write_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.open_capture) begin
            used_ff[open_idx_ff[IDX_W-1:0]] <= 1'b1;
         end
         if (cmd.take) begin
            used_ff[take_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_idx_ff  <= '0;
         scan_addr_ff <= '0;
         rd_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rev_hit_ff   <= 1'b0;
      end else begin
         if (cmd.chain_start) begin
            open_idx_ff <= '0;
         end else if (cmd.open_step) begin
            open_idx_ff <= open_idx_ff + CNT_W'(1);
         end
         rd_valid_ff <= cmd.scan_run && scan_more;
         if (cmd.scan_start) begin
            scan_addr_ff <= '0;
            fwd_hit_ff   <= 1'b0;
            rev_hit_ff   <= 1'b0;
         end else begin
            if (cmd.scan_run && scan_more) begin
               scan_addr_ff <= scan_addr_ff + CNT_W'(1);
            end
            if (fwd_match && !fwd_hit_ff) begin
               fwd_hit_ff <= 1'b1;
            end
            if (rev_match && !rev_hit_ff) begin
               rev_hit_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= scan_addr_ff[IDX_W-1:0];
      if (fwd_match && !fwd_hit_ff) begin
         fwd_idx_ff <= rd_idx_ff;
         fwd_pt_ff  <= end_q;
      end
      if (rev_match && !rev_hit_ff) begin
         rev_idx_ff <= rd_idx_ff;
         rev_pt_ff  <= start_q;
      end
      if (cmd.open_capture) begin
         ring_start_ff <= start_q;
         open_end_ff   <= end_q;
         pend_idx_ff   <= open_idx_ff[IDX_W-1:0];
         pend_rev_ff   <= 1'b0;
      end else if (cmd.take) begin
         open_end_ff <= fwd_hit_ff ? fwd_pt_ff : rev_pt_ff;
         pend_idx_ff <= take_idx;
         pend_rev_ff <= !fwd_hit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_idx_ff      <= pend_idx_ff;
         rsp_rev_ff      <= pend_rev_ff;
         rsp_ring_end_ff <= cmd.emit_ring_end;
         rsp_error_ff    <= cmd.emit_error;
         rsp_last_ff     <= cmd.emit_last;
      end
   end

   assign status.open_done = open_idx_ff >= count_ff;
   assign status.open_used = used_ff[open_idx_ff[IDX_W-1:0]];
   assign status.closed    = open_end_ff == ring_start_ff;
   assign status.scan_busy = scan_more || rd_valid_ff;
   assign status.any_hit   = fwd_hit_ff || rev_hit_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_segment_index = SEG_INDEX_W'(rsp_idx_ff);
   assign rsp_reversed      = rsp_rev_ff;
   assign rsp_ring_end      = rsp_ring_end_ff;
   assign rsp_chain_error   = rsp_error_ff;
   assign rsp_last          = rsp_last_ff;

   // The final word of a set either closes a ring or reports a dead end.
   a_last_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_ring_end_ff || rsp_error_ff)
      else $error("last word without ring end or error");

   a_end_or_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ring_end_ff && rsp_error_ff))
      else $error("ring end and error on one word");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SEGMENTS))
      else $error("segment count beyond table depth");

   a_emit_only_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten");

endmodule

`default_nettype wire

### src/pec_controller.sv
`default_nettype none

module pec_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_last_segment,
   output logic                         req_ready,
   input  wire pec_pkg::pec_status_type status,
   output pec_pkg::pec_cmd_type         cmd
);

   import pec_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_FIND_OPEN  = 4'd1;
   localparam logic [3:0] S_OPEN_DATA  = 4'd2;
   localparam logic [3:0] S_CHECK      = 4'd3;
   localparam logic [3:0] S_SCAN       = 4'd4;
   localparam logic [3:0] S_EMIT_MID   = 4'd5;
   localparam logic [3:0] S_EMIT_CLOSE = 4'd6;
   localparam logic [3:0] S_EMIT_FINAL = 4'd7;
   localparam logic [3:0] S_EMIT_DEAD  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       pend_ff;
   logic       pend_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_segment) begin
                  cmd.chain_start = 1'b1;
                  pend_in         = 1'b0;
                  state_in        = S_FIND_OPEN;
               end
            end
         end
         S_FIND_OPEN: begin
            if (status.open_done) begin
               if (pend_ff) begin
                  state_in = S_EMIT_FINAL;
               end else begin
                  cmd.clear_set = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (status.open_used) begin
               cmd.open_step = 1'b1;
            end else if (pend_ff) begin
               state_in = S_EMIT_CLOSE;
            end else begin
               state_in = S_OPEN_DATA;
            end
         end
         S_OPEN_DATA: begin
            cmd.open_capture = 1'b1;
            pend_in          = 1'b1;
            state_in         = S_CHECK;
         end
         S_CHECK: begin
            if (status.closed) begin
               state_in = S_FIND_OPEN;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (!status.scan_busy) begin
               state_in = status.any_hit ? S_EMIT_MID : S_EMIT_DEAD;
            end
         end
         S_EMIT_MID: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.take = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_EMIT_CLOSE: begin
            if (status.out_free) begin
               cmd.emit          = 1'b1;
               cmd.emit_ring_end = 1'b1;
               pend_in           = 1'b0;
               state_in          = S_FIND_OPEN;
            end
         end
         S_EMIT_FINAL: begin
            if (status.out_free) begin
               cmd.emit          = 1'b1;
               cmd.emit_ring_end = 1'b1;
               cmd.emit_last     = 1'b1;
               cmd.clear_set     = 1'b1;
               pend_in           = 1'b0;
               state_in          = S_IDLE;
            end
         end
         S_EMIT_DEAD: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_error = 1'b1;
               cmd.emit_last  = 1'b1;
               cmd.clear_set  = 1'b1;
               pend_in        = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   // A scan only starts from a ring that is still open.
   a_scan_needs_open: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_start |-> !status.closed)
      else $error("scan started on a closed ring");

   a_pending_on_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> pend_ff)
      else $error("word emitted with nothing pending");

   a_no_load_in_chain: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !cmd.load)
      else $error("segment loaded while chaining");

endmodule

`default_nettype wire
